/* hdl/tccs_pkg.sv */
// Shared widths, field offsets and controller/datapath command types of the trigger cell summer.
`default_nettype none

package tccs_pkg;

    localparam int TRIGGER_CELLS = 256;
    localparam int CELL_BITS     = 8;
    localparam int SUM_BITS      = 24;
    localparam int ADC_BITS      = 10;
    localparam int TOT_BITS      = 12;
    localparam int GAIN_BITS     = 8;
    localparam int CHARGE_BITS   = 20;

    // Input tdata layout, lowest bit first.
    localparam int IN_DATA_BITS  = 88;
    localparam int OFS_IDX       = 0;
    localparam int OFS_ADC       = OFS_IDX + CELL_BITS;
    localparam int OFS_TOT       = OFS_ADC + ADC_BITS;
    localparam int OFS_ADC_PED   = OFS_TOT + TOT_BITS;
    localparam int OFS_ADC_THR   = OFS_ADC_PED + ADC_BITS;
    localparam int OFS_TOT_PED   = OFS_ADC_THR + ADC_BITS;
    localparam int OFS_TOT_THR   = OFS_TOT_PED + TOT_BITS;
    localparam int OFS_GAIN      = OFS_TOT_THR + TOT_BITS;

    // Output tdata layout, lowest bit first.
    localparam int OUT_DATA_BITS = 48;

    localparam logic REQ_HIT     = 1'b0;
    localparam logic REQ_READOUT = 1'b1;

    localparam int SHIFT_FOUR    = 1;
    localparam int SHIFT_NINE    = 3;

    typedef struct packed {
        logic load;   // capture the accepted item
        logic rd;     // read the cell and compute the charge
        logic wr;     // update the cell and load the result register
    } t_dp_cmd;

endpackage

`default_nettype wire

/* hdl/tccs_ctrl.sv */
// Controller state machine: sequences accept, cell read and cell update for each item.
`default_nettype none

module tccs_ctrl
    import tccs_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  wire     i_m_tready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   wr_go;

    // The update may only proceed once the result register is free or being emptied.
    assign wr_go      = (r_state == S_WR) && (!r_out_valid || i_m_tready);
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.rd   = (r_state == S_RD);
        o_cmd.wr   = wr_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (wr_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (wr_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_load_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.rd)
        else $error("cell read did not follow an accepted item");

    a_read_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> (r_state == S_WR) && !o_s_tready)
        else $error("cell read not followed by the update step");

    a_update_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr |=> o_m_tvalid && o_s_tready)
        else $error("cell update did not present a result");

endmodule

`default_nettype wire

/* hdl/tccs_dp.sv */
// Datapath: charge linearization, cell sum memory with read-modify-write, result register.
`default_nettype none

module tccs_dp
    import tccs_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  wire                      i_cfg_we,
    input  wire                      i_cfg_wdata,
    input  wire                      i_req,
    input  wire [IN_DATA_BITS-1:0]   i_data,
    output logic [OUT_DATA_BITS-1:0] o_data
);

    // Configuration.
    logic r_nine_cell_mode;

    // Captured item.
    logic                 r_req;
    logic [CELL_BITS-1:0] r_idx;
    logic [ADC_BITS-1:0]  r_adc;
    logic [TOT_BITS-1:0]  r_tot;
    logic [ADC_BITS-1:0]  r_adc_ped;
    logic [ADC_BITS-1:0]  r_adc_thr;
    logic [TOT_BITS-1:0]  r_tot_ped;
    logic [TOT_BITS-1:0]  r_tot_thr;
    logic [GAIN_BITS-1:0] r_gain;

    // Read stage.
    logic [CHARGE_BITS-1:0] r_charge;
    logic [SUM_BITS-1:0]    r_rd_data;
    logic                   r_rd_valid;

    // Cell store; an entry whose valid bit is clear reads as zero.
    logic [SUM_BITS-1:0]      r_mem [TRIGGER_CELLS];
    logic [TRIGGER_CELLS-1:0] r_valid;

    // Result register.
    logic [CHARGE_BITS-1:0] r_out_charge;
    logic [SUM_BITS-1:0]    r_out_sum;
    logic                   r_out_present;

    logic [TOT_BITS-1:0]    eff_tot;
    logic [ADC_BITS:0]      adc_limit;
    logic [CHARGE_BITS-1:0] n_charge;
    logic [SUM_BITS-1:0]    stored;
    logic [SUM_BITS:0]      sum_ext;
    logic [SUM_BITS-1:0]    n_sum;
    logic [SUM_BITS-1:0]    shifted;
    logic                   mem_we;

    always_comb begin
        priority if ((r_tot > r_tot_thr) && (r_tot > r_tot_ped)) begin
            eff_tot = r_tot - r_tot_ped;
        end else if (r_tot_thr > r_tot_ped) begin
            eff_tot = r_tot_thr - r_tot_ped;
        end else begin
            eff_tot = '0;
        end

        adc_limit = {1'b0, r_adc_ped} + {1'b0, r_adc_thr};

        if (r_tot != '0) begin
            n_charge = {{(CHARGE_BITS-TOT_BITS){1'b0}}, eff_tot}
                     * {{(CHARGE_BITS-GAIN_BITS){1'b0}}, r_gain};
        end else if ({1'b0, r_adc} > adc_limit) begin
            n_charge = {{(CHARGE_BITS-ADC_BITS){1'b0}}, r_adc - r_adc_ped};
        end else begin
            n_charge = '0;
        end
    end

    always_comb begin
        stored  = r_rd_valid ? r_rd_data : '0;
        sum_ext = {1'b0, stored} + {{(SUM_BITS+1-CHARGE_BITS){1'b0}}, r_charge};
        n_sum   = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
        shifted = r_nine_cell_mode ? (stored >> SHIFT_NINE) : (stored >> SHIFT_FOUR);
        // Hits with zero charge leave the cell alone; readouts clear its valid bit.
        mem_we  = i_cmd.wr && (r_req == REQ_HIT) && (r_charge != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nine_cell_mode <= 1'b0;
            r_valid          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_nine_cell_mode <= i_cfg_wdata;
            end
            if (mem_we) begin
                r_valid[r_idx] <= 1'b1;
            end else if (i_cmd.wr && (r_req == REQ_READOUT)) begin
                r_valid[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= n_sum;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req;
            r_idx     <= i_data[OFS_IDX     +: CELL_BITS];
            r_adc     <= i_data[OFS_ADC     +: ADC_BITS];
            r_tot     <= i_data[OFS_TOT     +: TOT_BITS];
            r_adc_ped <= i_data[OFS_ADC_PED +: ADC_BITS];
            r_adc_thr <= i_data[OFS_ADC_THR +: ADC_BITS];
            r_tot_ped <= i_data[OFS_TOT_PED +: TOT_BITS];
            r_tot_thr <= i_data[OFS_TOT_THR +: TOT_BITS];
            r_gain    <= i_data[OFS_GAIN    +: GAIN_BITS];
        end
        if (i_cmd.rd) begin
            r_charge   <= n_charge;
            r_rd_valid <= r_valid[r_idx];
        end
        if (i_cmd.wr) begin
            if (r_req == REQ_HIT) begin
                r_out_charge  <= r_charge;
                r_out_sum     <= '0;
                r_out_present <= 1'b0;
            end else begin
                r_out_charge  <= '0;
                r_out_sum     <= shifted;
                r_out_present <= (stored != '0);
            end
        end
    end

    assign o_data = {{(OUT_DATA_BITS-CHARGE_BITS-SUM_BITS-1){1'b0}},
                     r_out_present, r_out_sum, r_out_charge};

endmodule

`default_nettype wire

/* hdl/trigger_cell_charge_summer_unit.sv */
// An accepted item passes the cell read state, then the update state that loads the result
// register. No new item is accepted before that update, as set by the read-modify-write of
// the cell sum memory, whose read data is registered before the saturating add and write-back.
// A waiting result stalls the next item's update step, and no item is accepted meanwhile.
// Reset (synchronous, active low) clears all cell sums at once through per-cell valid bits
// and sets four-cell mode; no clearing pass is needed.
`default_nettype none

module trigger_cell_charge_summer_unit
    import tccs_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire                      i_cfg_wdata,       // nine_cell_mode
    input  wire                      s_axis_tvalid,
    output logic                     s_axis_tready,
    // cell_index, adc_value, tot_value, adc_ped, adc_thr,
    // tot_ped, tot_thr, gain, zero fill
    input  wire [IN_DATA_BITS-1:0]   s_axis_tdata,
    input  wire                      s_axis_tuser,      // req_type
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    // channel_charge, cell_sum, cell_present, zero fill
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    t_dp_cmd cmd;

    tccs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd)
    );

    tccs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .o_data      (m_axis_tdata)
    );

endmodule

`default_nettype wire
